### design/dcfir_pkg.sv
// Shared types, constants and coefficient table for the dual-channel low-pass FIR.
package dcfir_pkg;

  localparam int DEF_TAPS           = 51;
  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int DEF_COEF_FRAC_BITS = 18;

  localparam int COEF_W     = 14;
  localparam int COEF_LEN   = 51;
  localparam int COEF_IDX_W = 7;

  localparam logic [COEF_W-1:0] LP_COEF [0:COEF_LEN-1] = '{
    14'd0,     14'd43,    14'd101,   14'd186,   14'd310,   14'd488,   14'd729,
    14'd1044,  14'd1441,  14'd1923,  14'd2493,  14'd3147,  14'd3878,  14'd4676,
    14'd5527,  14'd6412,  14'd7312,  14'd8204,  14'd9065,  14'd9870,  14'd10598,
    14'd11226, 14'd11736, 14'd12112, 14'd12342, 14'd12420, 14'd12342, 14'd12112,
    14'd11736, 14'd11226, 14'd10598, 14'd9870,  14'd9065,  14'd8204,  14'd7312,
    14'd6412,  14'd5527,  14'd4676,  14'd3878,  14'd3147,  14'd2493,  14'd1923,
    14'd1441,  14'd1044,  14'd729,   14'd488,   14'd310,   14'd186,   14'd101,
    14'd43,    14'd0
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } seq_state_t;

  typedef struct packed {
    logic valid;
    logic clear;
    logic last;
  } mac_ctl_t;

  // taps past the end of the table weigh zero
  function automatic logic [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] k);
    logic [COEF_W-1:0] c;
    c = '0;
    if (k < COEF_IDX_W'(COEF_LEN)) begin
      c = LP_COEF[k[5:0]];
    end
    return c;
  endfunction

endpackage

### design/dual_channel_fir_lowpass.sv
// Top level of the dual-channel low-pass FIR: history RAM, sequencer, MAC and output register.
//
// Each transfer carries a red and an infrared AC sample with their DC levels; both AC samples
// are filtered by a TAPS-tap low-pass FIR, rounded and saturated, and the DC levels are passed
// through. One two-lane multiply-accumulate unit steps through the taps, one tap per cycle,
// with the past samples read one per cycle from a single history RAM holding both channels.
// An item keeps the block busy from its transfer until its result enters the output
// register, so no new transfer is taken before then. The result sits in an output
// register, so the next item is taken while it waits. The history starts as all zero after
// reset, tracked by a fill count; no clearing pass is needed.
module dual_channel_fir_lowpass import dcfir_pkg::*; #(
  parameter int TAPS           = DEF_TAPS,
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] ac_red,
  input  logic        [SAMPLE_WIDTH-1:0] dc_red,
  input  logic signed [SAMPLE_WIDTH-1:0] ac_infrared,
  input  logic        [SAMPLE_WIDTH-1:0] dc_infrared,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_red,
  output logic        [SAMPLE_WIDTH-1:0] dc_red_out,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_infrared,
  output logic        [SAMPLE_WIDTH-1:0] dc_infrared_out
);

  localparam int HIST_LEN = TAPS - 1;
  localparam int ADDR_W   = $clog2(HIST_LEN);

  logic                           accept;
  logic                           commit;
  logic                           out_free;
  logic                           mac_done;
  mac_ctl_t                       ctl;
  logic        [COEF_W-1:0]       coef;
  logic signed [SAMPLE_WIDTH-1:0] sample_red;
  logic signed [SAMPLE_WIDTH-1:0] sample_ir;
  logic        [SAMPLE_WIDTH-1:0] result_red;
  logic        [SAMPLE_WIDTH-1:0] result_ir;
  logic                           ram_re;
  logic        [ADDR_W-1:0]       ram_raddr;
  logic        [2*SAMPLE_WIDTH-1:0] ram_rdata;
  logic                           ram_we;
  logic        [ADDR_W-1:0]       ram_waddr;
  logic        [2*SAMPLE_WIDTH-1:0] ram_wdata;
  logic        [SAMPLE_WIDTH-1:0] dc_red_q;
  logic        [SAMPLE_WIDTH-1:0] dc_ir_q;

  dcfir_ram #(
    .WIDTH (2 * SAMPLE_WIDTH),
    .DEPTH (HIST_LEN)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dcfir_seq #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .ac_red      (ac_red),
    .ac_infrared (ac_infrared),
    .accept      (accept),
    .out_free    (out_free),
    .mac_done    (mac_done),
    .commit      (commit),
    .ctl         (ctl),
    .coef        (coef),
    .sample_red  (sample_red),
    .sample_ir   (sample_ir),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  dcfir_mac #(
    .TAPS           (TAPS),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .coef       (coef),
    .sample_red (sample_red),
    .sample_ir  (sample_ir),
    .done       (mac_done),
    .result_red (result_red),
    .result_ir  (result_ir)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dc_red_q <= dc_red;
      dc_ir_q  <= dc_infrared;
    end
    if (commit) begin
      filtered_red      <= $signed(result_red);
      dc_red_out        <= dc_red_q;
      filtered_infrared <= $signed(result_ir);
      dc_infrared_out   <= dc_ir_q;
    end
  end

endmodule

### design/dcfir_ram.sv
// Generic simple dual-port RAM with registered read.
module dcfir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/dcfir_mac.sv
// Two-lane multiply-accumulate unit with rounding and saturation.
module dcfir_mac import dcfir_pkg::*; #(
  parameter int TAPS           = DEF_TAPS,
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mac_ctl_t                       ctl,
  input  logic        [COEF_W-1:0]       coef,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_red,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ir,
  output logic                           done,
  output logic        [SAMPLE_WIDTH-1:0] result_red,
  output logic        [SAMPLE_WIDTH-1:0] result_ir
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W + 1;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);

  localparam logic signed [ACC_W:0] HALF    = (ACC_W+1)'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W+1)'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_MIN = ~SAT_MAX;

  logic                     a_valid;
  logic                     a_clear;
  logic                     a_last;
  logic signed [PROD_W-1:0] prod_red;
  logic signed [PROD_W-1:0] prod_ir;
  logic signed [ACC_W-1:0]  acc_red;
  logic signed [ACC_W-1:0]  acc_ir;

  // round half up, floor shift, clamp
  function automatic logic [SAMPLE_WIDTH-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] q;
    s = (ACC_W+1)'(a) + HALF;
    q = s >>> COEF_FRAC_BITS;
    if (q > SAT_MAX) begin
      q = SAT_MAX;
    end else if (q < SAT_MIN) begin
      q = SAT_MIN;
    end
    return q[SAMPLE_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= ctl.valid;
      if (a_valid && a_last) begin
        done <= 1'b1;
      end else if (ctl.valid) begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_clear  <= ctl.clear;
    a_last   <= ctl.last;
    prod_red <= sample_red * $signed({1'b0, coef});
    prod_ir  <= sample_ir * $signed({1'b0, coef});
    if (a_valid) begin
      acc_red <= a_clear ? ACC_W'(prod_red) : acc_red + ACC_W'(prod_red);
      acc_ir  <= a_clear ? ACC_W'(prod_ir)  : acc_ir  + ACC_W'(prod_ir);
    end
  end

  assign result_red = round_sat(acc_red);
  assign result_ir  = round_sat(acc_ir);

endmodule

### design/dcfir_seq.sv
// Tap sequencer: input latch, history addressing, fill count and MAC operand feed.
module dcfir_seq import dcfir_pkg::*; #(
  parameter int TAPS         = DEF_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic        [SAMPLE_WIDTH-1:0]    ac_red,
  input  logic        [SAMPLE_WIDTH-1:0]    ac_infrared,
  output logic                              accept,
  input  logic                              out_free,
  input  logic                              mac_done,
  output logic                              commit,
  output mac_ctl_t                          ctl,
  output logic        [COEF_W-1:0]          coef,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_red,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_ir,
  output logic                              ram_re,
  output logic        [$clog2(TAPS-1)-1:0]  ram_raddr,
  input  logic        [2*SAMPLE_WIDTH-1:0]  ram_rdata,
  output logic                              ram_we,
  output logic        [$clog2(TAPS-1)-1:0]  ram_waddr,
  output logic        [2*SAMPLE_WIDTH-1:0]  ram_wdata
);

  localparam int HIST_LEN = TAPS - 1;
  localparam int ADDR_W   = $clog2(HIST_LEN);
  localparam int TAP_W    = $clog2(TAPS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HIST_LEN - 1);
  localparam logic [TAP_W-1:0]  LAST_TAP  = TAP_W'(TAPS - 1);
  localparam logic [TAP_W-1:0]  FULL_CNT  = TAP_W'(HIST_LEN);

  seq_state_t        state;
  seq_state_t        state_next;
  logic              issue;
  logic [TAP_W-1:0]  tap;
  logic [TAP_W-1:0]  count;
  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] wp_next;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] newest;
  logic [SAMPLE_WIDTH-1:0] x_red;
  logic [SAMPLE_WIDTH-1:0] x_ir;
  logic              s1_valid;
  logic              s1_first;
  logic              s1_last;
  logic              s1_use;
  logic [COEF_W-1:0] s1_coef;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_RUN;
      S_RUN:  if (tap == LAST_TAP) state_next = S_WAIT;
      S_WAIT: if (mac_done && out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = rst || (state != S_IDLE);
    accept   = in_valid && !in_stall;
    issue    = (state == S_RUN);
    commit   = (state == S_WAIT) && mac_done && out_free;
  end

  assign newest  = (wp == '0) ? LAST_ADDR : wp - ADDR_W'(1);
  assign wp_next = (wp == LAST_ADDR) ? '0 : wp + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      count    <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      if (commit) begin
        wp <= wp_next;
        if (count != FULL_CNT) begin
          count <= count + TAP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_red   <= ac_red;
      x_ir    <= ac_infrared;
      tap     <= '0;
      rd_addr <= newest;
    end else if (issue) begin
      tap <= tap + TAP_W'(1);
      if (tap != '0) begin
        rd_addr <= (rd_addr == '0) ? LAST_ADDR : rd_addr - ADDR_W'(1);
      end
    end
    s1_first <= (tap == '0);
    s1_last  <= (tap == LAST_TAP);
    s1_use   <= (tap != '0) && (tap <= count);
    s1_coef  <= coef_at(COEF_IDX_W'(tap));
  end

  assign ram_re    = issue && (tap != '0);
  assign ram_raddr = rd_addr;
  assign ram_we    = commit;
  assign ram_waddr = wp;
  assign ram_wdata = {x_red, x_ir};

  // unfilled history slots read as zero
  always_comb begin
    if (s1_first) begin
      sample_red = $signed(x_red);
      sample_ir  = $signed(x_ir);
    end else if (s1_use) begin
      sample_red = $signed(ram_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
      sample_ir  = $signed(ram_rdata[SAMPLE_WIDTH-1:0]);
    end else begin
      sample_red = '0;
      sample_ir  = '0;
    end
  end

  assign ctl  = '{valid: s1_valid, clear: s1_first, last: s1_last};
  assign coef = s1_coef;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("fill count beyond history length");

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    wp <= LAST_ADDR)
    else $error("write pointer out of range");

  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    commit |-> mac_done && !issue && !s1_valid)
    else $error("commit before accumulation finished");

  a_step_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(state == S_RUN))
    else $error("MAC step outside tap sweep");

endmodule

### bench/testbench.sv
// Self-checking bench for the dual-channel low-pass FIR: tracks both histories, checks results.
`timescale 1ns / 100ps

module testbench;
  import dcfir_pkg::*;

  localparam int SW        = DEF_SAMPLE_WIDTH;
  localparam int NTAPS     = DEF_TAPS;
  localparam int FRAC      = DEF_COEF_FRAC_BITS;
  localparam int HIST      = NTAPS - 1;
  localparam int N_RANDOM  = 800;
  localparam int LIMIT     = 600_000;
  localparam int SETTLE    = 2 * (NTAPS + 4) + 20;
  localparam int HOLD_LEN  = 500;

  localparam int TAP_WEIGHT [0:50] = '{
    0, 43, 101, 186, 310, 488, 729, 1044, 1441, 1923,
    2493, 3147, 3878, 4676, 5527, 6412, 7312, 8204, 9065, 9870,
    10598, 11226, 11736, 12112, 12342, 12420, 12342, 12112, 11736, 11226,
    10598, 9870, 9065, 8204, 7312, 6412, 5527, 4676, 3878, 3147,
    2493, 1923, 1441, 1044, 729, 488, 310, 186, 101, 43,
    0
  };

  typedef struct {
    logic signed [SW-1:0] filtered_red;
    logic        [SW-1:0] dc_red_out;
    logic signed [SW-1:0] filtered_infrared;
    logic        [SW-1:0] dc_infrared_out;
  } oxi_result_t;

  class fir_lowpass_ledger;
    logic signed [SW-1:0] past [2][HIST];
    oxi_result_t          pending_outputs [$];
    int unsigned          errors;
    int unsigned          matched;

    function new();
      for (int c = 0; c < 2; c++) begin
        for (int j = 0; j < HIST; j++) begin
          past[c][j] = '0;
        end
      end
      errors  = 0;
      matched = 0;
    endfunction

    function logic signed [SW-1:0] smooth(int ch, logic signed [SW-1:0] x);
      longint acc;
      longint r;
      acc = longint'(TAP_WEIGHT[0]) * longint'(x);
      for (int j = 0; j < HIST; j++) begin
        acc += longint'(TAP_WEIGHT[j + 1]) * longint'(past[ch][j]);
      end
      for (int j = HIST - 1; j > 0; j--) begin
        past[ch][j] = past[ch][j - 1];
      end
      past[ch][0] = x;
      r = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      if (r > longint'(32767)) r = longint'(32767);
      if (r < longint'(-32768)) r = longint'(-32768);
      return r[SW-1:0];
    endfunction

    function void take_sample(logic signed [SW-1:0] acr, logic [SW-1:0] dcr,
                              logic signed [SW-1:0] acir, logic [SW-1:0] dcir);
      oxi_result_t e;
      e.filtered_red      = smooth(0, acr);
      e.dc_red_out        = dcr;
      e.filtered_infrared = smooth(1, acir);
      e.dc_infrared_out   = dcir;
      pending_outputs.push_back(e);
    endfunction

    function void match_output(oxi_result_t got);
      oxi_result_t e;
      if (pending_outputs.size() == 0) begin
        $error("result transfer with no expected item waiting");
        errors++;
        return;
      end
      e = pending_outputs.pop_front();
      matched++;
      if (got.filtered_red !== e.filtered_red) begin
        $error("filtered_red: expected %0d, got %0d", e.filtered_red, got.filtered_red);
        errors++;
      end
      if (got.dc_red_out !== e.dc_red_out) begin
        $error("dc_red_out: expected %0d, got %0d", e.dc_red_out, got.dc_red_out);
        errors++;
      end
      if (got.filtered_infrared !== e.filtered_infrared) begin
        $error("filtered_infrared: expected %0d, got %0d", e.filtered_infrared,
               got.filtered_infrared);
        errors++;
      end
      if (got.dc_infrared_out !== e.dc_infrared_out) begin
        $error("dc_infrared_out: expected %0d, got %0d", e.dc_infrared_out,
               got.dc_infrared_out);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SW-1:0] ac_red = '0;
  logic        [SW-1:0] dc_red = '0;
  logic signed [SW-1:0] ac_infrared = '0;
  logic        [SW-1:0] dc_infrared = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SW-1:0] filtered_red;
  logic        [SW-1:0] dc_red_out;
  logic signed [SW-1:0] filtered_infrared;
  logic        [SW-1:0] dc_infrared_out;

  fir_lowpass_ledger ledger = new();
  bit                quiet_spell = 1'b0;
  int unsigned       sent = 0;
  int unsigned       cycles = 0;

  dual_channel_fir_lowpass u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .ac_red            (ac_red),
    .dc_red            (dc_red),
    .ac_infrared       (ac_infrared),
    .dc_infrared       (dc_infrared),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .filtered_red      (filtered_red),
    .dc_red_out        (dc_red_out),
    .filtered_infrared (filtered_infrared),
    .dc_infrared_out   (dc_infrared_out)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer(logic signed [SW-1:0] acr, logic [SW-1:0] dcr,
                       logic signed [SW-1:0] acir, logic [SW-1:0] dcir);
    while (!quiet_spell && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    ac_red      <= acr;
    dc_red      <= dcr;
    ac_infrared <= acir;
    dc_infrared <= dcir;
    do @(posedge clk); while (in_stall);
    ledger.take_sample(acr, dcr, acir, dcir);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [SW-1:0] any_word();
    return SW'($urandom);
  endfunction

  function automatic logic signed [SW-1:0] rail(bit hi);
    return hi ? 16'sh7fff : 16'sh8000;
  endfunction

  task automatic random_burst();
    int unsigned mode;
    int unsigned len;
    bit          hr;
    bit          hi;
    mode = $urandom_range(3);
    len  = (mode == 1) ? $urandom_range(60, 50) : $urandom_range(40, 5);
    hr   = 1'($urandom_range(1));
    hi   = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: offer(any_word(), any_word(), any_word(), any_word());
        // steady full-scale run, long enough to fill the whole history
        1: offer(rail(hr), any_word(), rail(hi), any_word());
        2: offer(SW'($urandom_range(64)) - 16'sd32, any_word(),
                 SW'($urandom_range(64)) - 16'sd32, any_word());
        default: offer(rail(i[0]), any_word(), rail(!i[0]), any_word());
      endcase
      if (sent >= 300 && sent < 420) quiet_spell = 1'b1;
      else quiet_spell = 1'b0;
    end
  endtask

  // receiver stall, with one long hold-off to back the block up
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && ledger.matched >= 150) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet_spell) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 34);
      end
    end
  end

  initial begin
    oxi_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.filtered_red      = filtered_red;
        got.dc_red_out        = dc_red_out;
        got.filtered_infrared = filtered_infrared;
        got.dc_infrared_out   = dc_infrared_out;
        ledger.match_output(got);
      end
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first sample meets an all-zero history
    offer(16'sh7fff, 16'h0000, 16'sh8000, 16'hffff);
    offer(16'sh8000, 16'hffff, 16'sh7fff, 16'h0000);
    offer(16'sh0000, 16'h0000, 16'sh0000, 16'h0000);
    offer(16'sh0001, 16'h0001, -16'sh0001, 16'h8000);
    offer(-16'sh0001, 16'haaaa, 16'sh0001, 16'h5555);
    offer(16'sh5555, 16'h5555, 16'shaaaa, 16'haaaa);
    offer(16'sh7fff, 16'h7fff, 16'sh7fff, 16'h7fff);
    offer(16'sh7fff, 16'h8000, 16'sh7fff, 16'h0001);
    offer(16'sh7fff, 16'hfffe, 16'sh7fff, 16'hfffe);
    offer(16'sh8000, 16'h0000, 16'sh8000, 16'h0000);
    offer(16'sh8000, 16'hffff, 16'sh8000, 16'hffff);
    offer(16'sh8000, 16'h1234, 16'sh8000, 16'h4321);
    for (int i = 0; i < 8; i++) begin
      offer(rail(i[0]), any_word(), rail(!i[0]), any_word());
    end

    while (sent < N_RANDOM + 20) begin
      if (!paused && sent >= 550) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        while (ledger.pending_outputs.size() != 0) @(negedge clk);
      end
      random_burst();
    end
    in_valid <= 1'b0;
    quiet_spell = 1'b0;

    while (ledger.pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending_outputs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
